// ===== rtl/tile_partition_2d_assert.svh =====
// assertion macros for the tile partition block
// used by tile_partition_2d; no other dependencies
`ifndef TILE_PARTITION_2D_ASSERT_SVH
`define TILE_PARTITION_2D_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TP2D_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TP2D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TP2D_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TP2D_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/tp2d_pkg.sv =====
// shared types and constants for the tile partition block
// no dependencies
package tp2d_pkg;

   localparam int NUM_W     = 34;
   localparam int DEN_W     = 17;
   localparam int CNT_W     = 6;
   localparam int FRAC_BITS = 16;

   localparam logic CSR_SOCKET_COUNT = 1'b0;
   localparam logic CSR_THREADS      = 1'b1;

   typedef struct packed {
      logic [15:0] rows_total;
      logic [15:0] cols_total;
      logic [23:0] target_ratio;
      logic        row_align;
      logic [2:0]  socket_index;
      logic [5:0]  thread_index;
   } req_data_type;

   typedef struct packed {
      logic [15:0] row_first;
      logic [15:0] row_limit;
      logic [15:0] col_first;
      logic [15:0] col_limit;
   } rsp_data_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
      logic [DEN_W-1:0] rem;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M,
      ST_BN0,
      ST_R0,
      ST_NEXT,
      ST_MOD,
      ST_CM,
      ST_CN,
      ST_BMC,
      ST_BNC,
      ST_RC,
      ST_TID,
      ST_MUL,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/tp2d_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on tp2d_pkg
module tp2d_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tp2d_pkg::div_req_type div_req,
   output tp2d_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tp2d_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [tp2d_pkg::NUM_W-1:0]    acc_ff, acc_in;
   logic [tp2d_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [tp2d_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [tp2d_pkg::DEN_W:0]      trial;
   logic [tp2d_pkg::DEN_W:0]      diff;
   logic                          ge;

   always_comb begin
      trial   = {rem_ff, acc_ff[tp2d_pkg::NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         // quotient bits shift in where numerator bits leave
         acc_in = {acc_ff[tp2d_pkg::NUM_W-2:0], ge};
         rem_in = ge ? diff[tp2d_pkg::DEN_W-1:0] : trial[tp2d_pkg::DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tp2d_pkg::CNT_W'(tp2d_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = acc_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

// ===== rtl/tile_partition_2d.sv =====
// channel  direction  handshake           payload
// req      in         req_valid/req_ready req_data (tp2d_pkg::req_data_type)
// rsp      out        rsp_valid/rsp_ready rsp_data (tp2d_pkg::rsp_data_type)
// csr      in         csr_we              csr_index, csr_data
//
// one item at a time; every division runs on the shared serial divider
// the search loop tries candidate divisors of the thread count in turn
// a new item is taken while the previous result waits on rsp
// reset: synchronous; registers return to one socket and one thread
// depends on tp2d_pkg, tp2d_div and tile_partition_2d_assert.svh
`include "tile_partition_2d_assert.svh"
module tile_partition_2d #(
   parameter int MAX_THREADS = 64,
   parameter int MAX_SOCKETS = 8,
   parameter int DIM_BITS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tp2d_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tp2d_pkg::rsp_data_type rsp_data,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [6:0]             csr_data
);

   localparam int TW = $clog2(MAX_THREADS + 2);
   localparam int SW = $clog2(MAX_SOCKETS + 1);
   localparam logic [15:0] DimMask = (DIM_BITS >= 16) ? 16'hFFFF
                                     : 16'((1 << DIM_BITS) - 1);
   localparam int NW = tp2d_pkg::NUM_W;
   localparam int DW = tp2d_pkg::DEN_W;

   tp2d_pkg::state_type    state_ff, state_in;
   logic [3:0]             sockets_ff, sockets_in;
   logic [6:0]             threads_ff, threads_in;
   logic                   issued_ff, issued_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tp2d_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic [15:0] m_all_ff, m_all_in;
   logic [15:0] n_ff, n_in;
   logic [23:0] tgt_ff, tgt_in;
   logic        align_ff, align_in;
   logic [2:0]  sock_ff, sock_in;
   logic [5:0]  tid_ff, tid_in;
   logic [SW-1:0] ns_ff, ns_in;
   logic [TW-1:0] nt_ff, nt_in;
   logic [TW-1:0] mc_ff, mc_in;
   logic [TW-1:0] nc_ff, nc_in;
   logic [TW-1:0] nb_ff, nb_in;
   logic [15:0] m_ff, m_in;
   logic [16:0] bm_ff, bm_in;
   logic [16:0] bn_ff, bn_in;
   logic [16:0] bmc_ff, bmc_in;
   logic [16:0] bnc_ff, bnc_in;
   logic [NW-1:0] best_ff, best_in;
   logic [5:0]  m_tid_ff, m_tid_in;
   logic [5:0]  n_tid_ff, n_tid_in;
   logic [15:0] mb_begin_ff, mb_begin_in;
   logic [15:0] mb_end_ff, mb_end_in;
   logic [15:0] n_begin_ff, n_begin_in;
   logic [15:0] n_end_ff, n_end_in;
   logic [15:0] sock_first_ff, sock_first_in;

   logic [8:0]    thr_ext;
   logic [4:0]    sock_ext;
   logic [TW-1:0] nt_eff;
   logic [SW-1:0] ns_eff;
   logic [16:0]   mq, nq;
   logic [NW-1:0] gap;
   logic [22:0]   prod_m, prod_n;
   logic [18:0]   prod_s;
   logic [17:0]   sum_m, sum_n;
   logic [16:0]   sum_rf, sum_rl;

   tp2d_pkg::div_req_type div_req;
   tp2d_pkg::div_rsp_type div_rsp;

   tp2d_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // clamp register values to the supported range
   always_comb begin
      thr_ext  = 9'(threads_ff);
      sock_ext = 5'(sockets_ff);
      if (thr_ext == 9'd0) begin
         nt_eff = TW'(1);
      end else if (32'(thr_ext) > MAX_THREADS) begin
         nt_eff = TW'(MAX_THREADS);
      end else begin
         nt_eff = TW'(thr_ext);
      end
      if (sock_ext == 5'd0) begin
         ns_eff = SW'(1);
      end else if (32'(sock_ext) > MAX_SOCKETS) begin
         ns_eff = SW'(MAX_SOCKETS);
      end else begin
         ns_eff = SW'(sock_ext);
      end
   end

   always_comb begin
      mq  = (17'(m_ff) + 17'd15) >> 4;
      nq  = (17'(n_ff) + 17'd15) >> 4;
      gap = (div_rsp.quo > NW'(tgt_ff)) ? div_rsp.quo - NW'(tgt_ff)
                                        : NW'(tgt_ff) - div_rsp.quo;
      prod_m = 23'(m_tid_ff) * 23'(bm_ff);
      prod_n = 23'(n_tid_ff) * 23'(bn_ff);
      prod_s = 19'(sock_ff) * 19'(m_ff);
      sum_m  = 18'(mb_begin_ff) + 18'(bm_ff);
      sum_n  = 18'(n_begin_ff) + 18'(bn_ff);
      sum_rf = 17'(sock_first_ff) + 17'(mb_begin_ff);
      sum_rl = 17'(sock_first_ff) + 17'(mb_end_ff);
   end

   always_comb begin
      state_in      = state_ff;
      sockets_in    = sockets_ff;
      threads_in    = threads_ff;
      issued_in     = issued_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      m_all_in      = m_all_ff;
      n_in          = n_ff;
      tgt_in        = tgt_ff;
      align_in      = align_ff;
      sock_in       = sock_ff;
      tid_in        = tid_ff;
      ns_in         = ns_ff;
      nt_in         = nt_ff;
      mc_in         = mc_ff;
      nc_in         = nc_ff;
      nb_in         = nb_ff;
      m_in          = m_ff;
      bm_in         = bm_ff;
      bn_in         = bn_ff;
      bmc_in        = bmc_ff;
      bnc_in        = bnc_ff;
      best_in       = best_ff;
      m_tid_in      = m_tid_ff;
      n_tid_in      = n_tid_ff;
      mb_begin_in   = mb_begin_ff;
      mb_end_in     = mb_end_ff;
      n_begin_in    = n_begin_ff;
      n_end_in      = n_end_ff;
      sock_first_in = sock_first_ff;
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      req_ready     = (state_ff == tp2d_pkg::ST_IDLE);

      if (csr_we) begin
         case (csr_index)
            tp2d_pkg::CSR_SOCKET_COUNT: sockets_in = csr_data[3:0];
            tp2d_pkg::CSR_THREADS:      threads_in = csr_data;
            default: ;
         endcase
      end

      // operands of the division that the current step needs
      case (state_ff)
         tp2d_pkg::ST_M: begin
            div_req.num = NW'(m_all_ff) + NW'(ns_ff) - NW'(1);
            div_req.den = DW'(ns_ff);
         end
         tp2d_pkg::ST_BN0: begin
            div_req.num = NW'(nq) + NW'(nt_ff) - NW'(1);
            div_req.den = DW'(nt_ff);
         end
         tp2d_pkg::ST_R0: begin
            div_req.num = NW'(bm_ff) << tp2d_pkg::FRAC_BITS;
            div_req.den = bn_ff;
         end
         tp2d_pkg::ST_MOD: begin
            div_req.num = NW'(nt_ff);
            div_req.den = DW'(mc_ff);
         end
         tp2d_pkg::ST_CM: begin
            div_req.num = NW'(m_ff) + NW'(mc_ff) - NW'(1);
            div_req.den = DW'(mc_ff);
         end
         tp2d_pkg::ST_CN: begin
            div_req.num = NW'(n_ff) + NW'(nc_ff) - NW'(1);
            div_req.den = DW'(nc_ff);
         end
         tp2d_pkg::ST_BMC: begin
            div_req.num = (align_ff ? NW'(mq) : NW'(m_ff)) + NW'(mc_ff) - NW'(1);
            div_req.den = DW'(mc_ff);
         end
         tp2d_pkg::ST_BNC: begin
            div_req.num = NW'(nq) + NW'(nc_ff) - NW'(1);
            div_req.den = DW'(nc_ff);
         end
         tp2d_pkg::ST_RC: begin
            div_req.num = NW'(bmc_ff) << tp2d_pkg::FRAC_BITS;
            div_req.den = bnc_ff;
         end
         tp2d_pkg::ST_TID: begin
            div_req.num = NW'(tid_ff);
            div_req.den = DW'(nb_ff);
         end
         default: ;
      endcase

      case (state_ff)
         tp2d_pkg::ST_M, tp2d_pkg::ST_BN0, tp2d_pkg::ST_R0, tp2d_pkg::ST_MOD,
         tp2d_pkg::ST_CM, tp2d_pkg::ST_CN, tp2d_pkg::ST_BMC, tp2d_pkg::ST_BNC,
         tp2d_pkg::ST_RC, tp2d_pkg::ST_TID: begin
            if (!issued_ff) begin
               div_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (div_rsp.done) begin
               issued_in = 1'b0;
            end
         end
         default: ;
      endcase

      case (state_ff)
         tp2d_pkg::ST_IDLE: begin
            if (req_valid) begin
               m_all_in = req_data.rows_total & DimMask;
               n_in     = req_data.cols_total & DimMask;
               tgt_in   = req_data.target_ratio;
               align_in = req_data.row_align;
               sock_in  = req_data.socket_index;
               tid_in   = req_data.thread_index;
               ns_in    = ns_eff;
               nt_in    = nt_eff;
               mc_in    = TW'(2);
               state_in = tp2d_pkg::ST_M;
            end
         end
         tp2d_pkg::ST_M: begin
            if (issued_ff && div_rsp.done) begin
               m_in     = div_rsp.quo[15:0];
               state_in = tp2d_pkg::ST_BN0;
            end
         end
         tp2d_pkg::ST_BN0: begin
            if (issued_ff && div_rsp.done) begin
               bn_in = {div_rsp.quo[12:0], 4'b0000};
               bm_in = align_ff ? {mq[12:0], 4'b0000} : 17'(m_ff);
               nb_in = nt_ff;
               if (div_rsp.quo[12:0] == 13'd0) begin
                  // no columns: ratio counts as zero
                  best_in  = NW'(tgt_ff);
                  state_in = tp2d_pkg::ST_NEXT;
               end else begin
                  state_in = tp2d_pkg::ST_R0;
               end
            end
         end
         tp2d_pkg::ST_R0: begin
            if (issued_ff && div_rsp.done) begin
               best_in  = gap;
               state_in = tp2d_pkg::ST_NEXT;
            end
         end
         tp2d_pkg::ST_NEXT: begin
            state_in = (mc_ff > nt_ff) ? tp2d_pkg::ST_TID : tp2d_pkg::ST_MOD;
         end
         tp2d_pkg::ST_MOD: begin
            if (issued_ff && div_rsp.done) begin
               if (div_rsp.rem != '0) begin
                  mc_in    = mc_ff + 1'b1;
                  state_in = tp2d_pkg::ST_NEXT;
               end else begin
                  nc_in    = TW'(div_rsp.quo);
                  state_in = tp2d_pkg::ST_CM;
               end
            end
         end
         tp2d_pkg::ST_CM: begin
            if (issued_ff && div_rsp.done) begin
               if (align_ff && ((tgt_ff < 24'd65536 && bm_ff == 17'd16
                                 && div_rsp.quo[15:0] < 16'd16)
                                || div_rsp.quo[15:0] <= 16'd8)) begin
                  mc_in    = mc_ff + 1'b1;
                  state_in = tp2d_pkg::ST_NEXT;
               end else begin
                  state_in = tp2d_pkg::ST_CN;
               end
            end
         end
         tp2d_pkg::ST_CN: begin
            if (issued_ff && div_rsp.done) begin
               if (div_rsp.quo[15:0] <= 16'd8) begin
                  mc_in    = mc_ff + 1'b1;
                  state_in = tp2d_pkg::ST_NEXT;
               end else begin
                  state_in = tp2d_pkg::ST_BMC;
               end
            end
         end
         tp2d_pkg::ST_BMC: begin
            if (issued_ff && div_rsp.done) begin
               bmc_in   = align_ff ? {div_rsp.quo[12:0], 4'b0000} : div_rsp.quo[16:0];
               state_in = tp2d_pkg::ST_BNC;
            end
         end
         tp2d_pkg::ST_BNC: begin
            if (issued_ff && div_rsp.done) begin
               bnc_in   = {div_rsp.quo[12:0], 4'b0000};
               state_in = tp2d_pkg::ST_RC;
            end
         end
         tp2d_pkg::ST_RC: begin
            if (issued_ff && div_rsp.done) begin
               if (gap < best_ff) begin
                  best_in  = gap;
                  bm_in    = bmc_ff;
                  bn_in    = bnc_ff;
                  nb_in    = nc_ff;
                  mc_in    = mc_ff + 1'b1;
                  state_in = tp2d_pkg::ST_NEXT;
               end else begin
                  state_in = tp2d_pkg::ST_TID;
               end
            end
         end
         tp2d_pkg::ST_TID: begin
            if (issued_ff && div_rsp.done) begin
               m_tid_in = div_rsp.quo[5:0];
               n_tid_in = div_rsp.rem[5:0];
               state_in = tp2d_pkg::ST_MUL;
            end
         end
         tp2d_pkg::ST_MUL: begin
            mb_begin_in   = (prod_m < 23'(m_ff)) ? prod_m[15:0] : m_ff;
            n_begin_in    = (prod_n < 23'(n_ff)) ? prod_n[15:0] : n_ff;
            sock_first_in = (prod_s < 19'(m_all_ff)) ? prod_s[15:0] : m_all_ff;
            state_in      = tp2d_pkg::ST_FIN;
         end
         tp2d_pkg::ST_FIN: begin
            mb_end_in = (sum_m < 18'(m_ff)) ? sum_m[15:0] : m_ff;
            n_end_in  = (sum_n < 18'(n_ff)) ? sum_n[15:0] : n_ff;
            state_in  = tp2d_pkg::ST_OUT;
         end
         tp2d_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.row_first = (sum_rf < 17'(m_all_ff)) ? sum_rf[15:0] : m_all_ff;
               rsp_data_in.row_limit = (sum_rl < 17'(m_all_ff)) ? sum_rl[15:0] : m_all_ff;
               rsp_data_in.col_first = n_begin_ff;
               rsp_data_in.col_limit = n_end_ff;
               rsp_valid_in          = 1'b1;
               state_in              = tp2d_pkg::ST_IDLE;
            end
         end
         default: state_in = tp2d_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tp2d_pkg::ST_IDLE;
         sockets_ff   <= 4'd1;
         threads_ff   <= 7'd1;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sockets_ff   <= sockets_in;
         threads_ff   <= threads_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      m_all_ff      <= m_all_in;
      n_ff          <= n_in;
      tgt_ff        <= tgt_in;
      align_ff      <= align_in;
      sock_ff       <= sock_in;
      tid_ff        <= tid_in;
      ns_ff         <= ns_in;
      nt_ff         <= nt_in;
      mc_ff         <= mc_in;
      nc_ff         <= nc_in;
      nb_ff         <= nb_in;
      m_ff          <= m_in;
      bm_ff         <= bm_in;
      bn_ff         <= bn_in;
      bmc_ff        <= bmc_in;
      bnc_ff        <= bnc_in;
      best_ff       <= best_in;
      m_tid_ff      <= m_tid_in;
      n_tid_ff      <= n_tid_in;
      mb_begin_ff   <= mb_begin_in;
      mb_end_ff     <= mb_end_in;
      n_begin_ff    <= n_begin_in;
      n_end_ff      <= n_end_in;
      sock_first_ff <= sock_first_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TP2D_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == tp2d_pkg::ST_M)
   `TP2D_ASSERT_IMPLY(a_rows_ordered, clock, reset, rsp_valid, rsp_data.row_first <= rsp_data.row_limit)
   `TP2D_ASSERT_IMPLY(a_cols_ordered, clock, reset, rsp_valid, rsp_data.col_first <= rsp_data.col_limit)
   `TP2D_ASSERT_IMPLY(a_div_done_issued, clock, reset, div_rsp.done, issued_ff)

endmodule
